/* hw/rtl/cs_pkg.sv */
// shared types and constants for the comment stripper
`default_nettype none

package cs_pkg;

    // character codes
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    // result beats per input byte at most, and result queue sizing
    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int NUM_W      = $clog2(MAX_RES + 1);

    // width of the reported line number
    localparam int OUT_LINE_W = 16;

    // result kinds
    typedef enum logic [1:0] {
        KIND_TEXT       = 2'd0,
        KIND_STR_NL     = 2'd1,
        KIND_OPEN_BLOCK = 2'd2,
        KIND_END        = 2'd3
    } kind_t;

    // scanner modes
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_STAR   = 3'd4,
        MODE_STRING = 3'd5,
        MODE_BSL    = 3'd6,
        MODE_ERROR  = 3'd7
    } mode_t;

    // one result beat
    typedef struct packed {
        logic                  last;
        logic [OUT_LINE_W-1:0] line;
        logic [7:0]            data;
        kind_t                 kind;
    } result_t;

    // results handed from the scanner to the output queue
    typedef struct packed {
        logic [NUM_W-1:0]          cnt;
        result_t [MAX_RES-1:0]     item;
    } push_t;

endpackage

`default_nettype wire

/* hw/rtl/cs_in_reg.sv */
// input register holding one source byte ahead of the scanner
`default_nettype none

module cs_in_reg (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       take,
    output logic            in_valid,
    output logic [7:0]      in_byte,
    output logic            in_last
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // free when empty or when the held byte is consumed this cycle
    assign s_tready = !valid_reg || take;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;
    assign in_last  = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/cs_scan.sv */
// scanner: mode and line count, turns one byte into up to three results
`default_nettype none

module cs_scan #(
    parameter int LINE_BITS = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    input  wire logic [7:0]              in_byte,
    input  wire logic                    in_last,
    input  wire logic [cs_pkg::CNT_W-1:0] free,
    output logic                         fire,
    output cs_pkg::push_t                push
);

    localparam int EXT_W = (LINE_BITS > cs_pkg::OUT_LINE_W) ? LINE_BITS : cs_pkg::OUT_LINE_W;

    typedef enum logic [1:0] {
        SUB_NONE,
        SUB_NORMAL,
        SUB_STRING
    } sub_t;

    cs_pkg::mode_t  mode_reg, mode_next;
    logic [LINE_BITS-1:0] line_reg;
    logic [LINE_BITS-1:0] ln_v;
    logic [cs_pkg::NUM_W-1:0] n_v;
    cs_pkg::result_t [cs_pkg::MAX_RES-1:0] items_v;
    sub_t sub_v;

    logic is_star, is_slash, is_nl, is_quote, is_bsl;

    assign is_star  = (in_byte == cs_pkg::CH_STAR);
    assign is_slash = (in_byte == cs_pkg::CH_SLASH);
    assign is_nl    = (in_byte == cs_pkg::CH_NL);
    assign is_quote = (in_byte == cs_pkg::CH_QUOTE);
    assign is_bsl   = (in_byte == cs_pkg::CH_BSL);

    // saturating line increment
    function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] l);
        return (l == '1) ? l : l + 1'b1;
    endfunction

    // build one result beat, line number clipped to the report width
    function automatic cs_pkg::result_t mk(input cs_pkg::kind_t k, input logic [7:0] d,
                                           input logic [LINE_BITS-1:0] l);
        cs_pkg::result_t r;
        logic [EXT_W-1:0] e;
        e      = EXT_W'(l);
        r.kind = k;
        r.data = (k == cs_pkg::KIND_TEXT) ? d : 8'd0;
        r.line = (e > EXT_W'({cs_pkg::OUT_LINE_W{1'b1}})) ? {cs_pkg::OUT_LINE_W{1'b1}}
                                                           : e[cs_pkg::OUT_LINE_W-1:0];
        r.last = (k == cs_pkg::KIND_END);
        return r;
    endfunction

    // next mode
    always_comb begin
        mode_next = mode_reg;
        unique case (mode_reg)
            cs_pkg::MODE_NORMAL, cs_pkg::MODE_SLASH: begin
                if (mode_reg == cs_pkg::MODE_SLASH && is_slash) begin
                    mode_next = cs_pkg::MODE_LINE;
                end else if (mode_reg == cs_pkg::MODE_SLASH && is_star) begin
                    mode_next = cs_pkg::MODE_BLOCK;
                end else if (is_slash && !in_last) begin
                    mode_next = cs_pkg::MODE_SLASH;
                end else if (is_quote) begin
                    mode_next = cs_pkg::MODE_STRING;
                end else begin
                    mode_next = cs_pkg::MODE_NORMAL;
                end
            end
            cs_pkg::MODE_LINE: begin
                if (is_nl) begin
                    mode_next = cs_pkg::MODE_NORMAL;
                end
            end
            cs_pkg::MODE_BLOCK, cs_pkg::MODE_STAR: begin
                if (mode_reg == cs_pkg::MODE_STAR && is_slash) begin
                    mode_next = cs_pkg::MODE_NORMAL;
                end else if (is_star) begin
                    mode_next = cs_pkg::MODE_STAR;
                end else begin
                    mode_next = cs_pkg::MODE_BLOCK;
                end
            end
            cs_pkg::MODE_STRING, cs_pkg::MODE_BSL: begin
                // an escaped quote keeps the string open
                if (mode_reg == cs_pkg::MODE_BSL && is_quote) begin
                    mode_next = cs_pkg::MODE_STRING;
                end else if (is_bsl && !in_last) begin
                    mode_next = cs_pkg::MODE_BSL;
                end else if (is_quote) begin
                    mode_next = cs_pkg::MODE_NORMAL;
                end else if (is_nl) begin
                    mode_next = cs_pkg::MODE_ERROR;
                end else begin
                    mode_next = cs_pkg::MODE_STRING;
                end
            end
            cs_pkg::MODE_ERROR: begin
                mode_next = cs_pkg::MODE_ERROR;
            end
        endcase
    end

    // result beats and line count after this byte
    always_comb begin
        items_v = '0;
        n_v     = '0;
        ln_v    = line_reg;
        sub_v   = SUB_NONE;

        // held character and mode specific beats
        unique case (mode_reg)
            cs_pkg::MODE_NORMAL: begin
                sub_v = SUB_NORMAL;
            end
            cs_pkg::MODE_SLASH: begin
                if (!is_slash && !is_star) begin
                    items_v[n_v] = mk(cs_pkg::KIND_TEXT, cs_pkg::CH_SLASH, ln_v);
                    n_v          = n_v + 1'b1;
                    sub_v        = SUB_NORMAL;
                end
            end
            cs_pkg::MODE_LINE, cs_pkg::MODE_BLOCK, cs_pkg::MODE_STAR: begin
                // newlines survive comments; a star-slash ending consumes the slash
                if (is_nl) begin
                    items_v[n_v] = mk(cs_pkg::KIND_TEXT, cs_pkg::CH_NL, ln_v);
                    n_v          = n_v + 1'b1;
                    ln_v         = line_inc(ln_v);
                end
            end
            cs_pkg::MODE_STRING: begin
                sub_v = SUB_STRING;
            end
            cs_pkg::MODE_BSL: begin
                items_v[n_v] = mk(cs_pkg::KIND_TEXT, cs_pkg::CH_BSL, ln_v);
                n_v          = n_v + 1'b1;
                if (is_quote) begin
                    items_v[n_v] = mk(cs_pkg::KIND_TEXT, cs_pkg::CH_QUOTE, ln_v);
                    n_v          = n_v + 1'b1;
                end else begin
                    sub_v = SUB_STRING;
                end
            end
            cs_pkg::MODE_ERROR: begin
                sub_v = SUB_NONE;
            end
        endcase

        // ordinary text or string byte
        unique case (sub_v)
            SUB_NORMAL: begin
                if (!(is_slash && !in_last)) begin
                    items_v[n_v] = mk(cs_pkg::KIND_TEXT, in_byte, ln_v);
                    n_v          = n_v + 1'b1;
                    if (is_nl) begin
                        ln_v = line_inc(ln_v);
                    end
                end
            end
            SUB_STRING: begin
                if (is_nl) begin
                    items_v[n_v] = mk(cs_pkg::KIND_STR_NL, 8'd0, ln_v);
                    n_v          = n_v + 1'b1;
                end else if (!(is_bsl && !in_last)) begin
                    items_v[n_v] = mk(cs_pkg::KIND_TEXT, in_byte, ln_v);
                    n_v          = n_v + 1'b1;
                end
            end
            default: begin
                n_v = n_v;
            end
        endcase

        // end of text reports
        if (in_last) begin
            if (mode_next == cs_pkg::MODE_BLOCK || mode_next == cs_pkg::MODE_STAR) begin
                items_v[n_v] = mk(cs_pkg::KIND_OPEN_BLOCK, 8'd0, ln_v);
                n_v          = n_v + 1'b1;
            end
            items_v[n_v] = mk(cs_pkg::KIND_END, 8'd0, ln_v);
            n_v          = n_v + 1'b1;
        end
    end

    // consume the byte once the queue has room for all its results
    assign fire      = in_valid && (cs_pkg::CNT_W'(n_v) <= free);
    assign push.cnt  = fire ? n_v : '0;
    assign push.item = items_v;

    // mode and line count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= cs_pkg::MODE_NORMAL;
            line_reg <= LINE_BITS'(1);
        end else if (fire) begin
            if (in_last) begin
                mode_reg <= cs_pkg::MODE_NORMAL;
                line_reg <= LINE_BITS'(1);
            end else begin
                mode_reg <= mode_next;
                line_reg <= ln_v;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/cs_out_fifo.sv */
// four-entry result queue, up to three writes and one read per cycle
`default_nettype none

module cs_out_fifo (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire cs_pkg::push_t           push,
    output logic [cs_pkg::CNT_W-1:0]     free,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output cs_pkg::result_t              head
);

    cs_pkg::result_t             fifo_reg [cs_pkg::FIFO_DEPTH];
    logic [cs_pkg::PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [cs_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                        pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    assign head     = fifo_reg[rd_ptr_reg];
    assign free     = cs_pkg::CNT_W'(cs_pkg::FIFO_DEPTH) - count_reg;

    assign count_next = count_reg + cs_pkg::CNT_W'(push.cnt) - cs_pkg::CNT_W'(pop);

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + cs_pkg::PTR_W'(push.cnt);
            rd_ptr_reg <= rd_ptr_reg + cs_pkg::PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    // entry writes
    always_ff @(posedge aclk) begin
        for (int i = 0; i < cs_pkg::MAX_RES; i++) begin
            if (cs_pkg::NUM_W'(i) < push.cnt) begin
                fifo_reg[wr_ptr_reg + cs_pkg::PTR_W'(i)] <= push.item[i];
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/comment_stripper_core.sv */
// top level of the comment stripper
//
// Takes source text one byte per beat on the s_ channel (s_tdata byte,
// s_tlast on the final byte of a text) and gives the kept text on the
// m_ channel: m_tdata holds the byte and the line number, m_tuser the
// kind (text, string broken by newline, open block comment, end of text)
// and m_tlast the end-of-text beat that closes every text.
// An accepted byte passes the input register and the result queue before its first result beat.
// One byte is taken per cycle while each byte gives at most one result;
// the m_ channel moves one result per cycle, so a byte that releases a
// held slash or backslash, or a final byte, can briefly hold off s_tready
// when the queue lacks room for all of its results.
// A four-entry result queue behind the scanner lets input continue
// while the receiver stalls, until the queue cannot take a byte's results.
// After reset the scanner is in plain text mode with line one and the
// queue is empty; the final byte of each text restores the scanner state.
`default_nettype none

module comment_stripper_core #(
    parameter int LINE_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] out_line
    output logic [1:0]       m_tuser,   // [1:0] out_kind
    output logic             m_tlast
);

    logic                    take;
    logic                    in_valid;
    logic [7:0]              in_byte;
    logic                    in_last;
    logic [cs_pkg::CNT_W-1:0] free;
    cs_pkg::push_t           push;
    cs_pkg::result_t         head;

    // input register
    cs_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .take     (take),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_last  (in_last)
    );

    // scanner
    cs_scan #(
        .LINE_BITS (LINE_BITS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .free     (free),
        .fire     (take),
        .push     (push)
    );

    // result queue
    cs_out_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    // result beat
    assign m_tdata = {head.line, head.data};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

`default_nettype wire

/* hw/rtl/cs_checker.sv */
// port checks for the comment stripper, bound to the top level
`default_nettype none

module cs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // queue empties and input opens on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result beat valid or input closed after reset");

    // tlast marks exactly the end-of-text beat
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == cs_pkg::KIND_END)))
        else $error("tlast and end-of-text kind disagree");

    // report beats carry no byte
    a_report_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != cs_pkg::KIND_TEXT) |-> (m_tdata[7:0] == 8'd0))
        else $error("report beat carries a byte");

    // line numbers start at one
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:8] != 16'd0))
        else $error("line number zero");

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result beat changed");

endmodule

bind comment_stripper_core cs_checker u_cs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/comment_stripper_core_tb.sv */
// self-checking testbench for the comment stripper core
`timescale 1ns / 1ps

module comment_stripper_core_tb;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    // receiver stall styles
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_style_t;

    // one row of the directed table; typed rows carry their own results
    typedef struct packed {
        logic [7:0]                data;
        logic                      last;
        logic                      typed;
        logic [1:0]                n_res;
        cs_pkg::result_t [2:0]     res;
    } dir_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // [7:0] out_byte, [23:8] out_line
    logic [1:0]  m_tuser;   // [1:0] out_kind
    logic        m_tlast;

    // predictor state and the beats it still waits for
    cs_pkg::mode_t                 mode_q = cs_pkg::MODE_NORMAL;
    logic [cs_pkg::OUT_LINE_W-1:0] line_q = cs_pkg::OUT_LINE_W'(1);
    bit                            rec_on;
    cs_pkg::result_t               pending_beats[$];

    int          mismatches  = 0;
    int          burst_left  = 0;
    int          hold_asks   = 0;
    int unsigned cycle_cnt   = 0;
    logic [7:0]  text_q[$];
    dir_row_t    dir_tab[$];

    comment_stripper_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // free-running cycle count
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------
    // queue helpers
    // ---------------------------------------------------------------

    task automatic add_beat(input cs_pkg::result_t r);
        pending_beats.insert(pending_beats.size(), r);
    endtask

    task automatic add_text(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    task automatic emit(input cs_pkg::kind_t k, input logic [7:0] d, input logic fin);
        cs_pkg::result_t r;
        r.kind = k;
        r.data = (k == cs_pkg::KIND_TEXT) ? d : 8'h00;
        r.line = line_q;
        r.last = fin;
        if (rec_on) add_beat(r);
    endtask

    // newline is always kept and ends the current line
    task automatic pass_newline();
        emit(cs_pkg::KIND_TEXT, cs_pkg::CH_NL, 1'b0);
        if (line_q != '1) line_q = line_q + 1'b1;
    endtask

    task automatic plain_byte(input logic [7:0] b, input logic last);
        if (b == cs_pkg::CH_SLASH) begin
            if (last) emit(cs_pkg::KIND_TEXT, b, 1'b0);
            else mode_q = cs_pkg::MODE_SLASH;
        end else if (b == cs_pkg::CH_QUOTE) begin
            emit(cs_pkg::KIND_TEXT, b, 1'b0);
            mode_q = cs_pkg::MODE_STRING;
        end else if (b == cs_pkg::CH_NL) begin
            pass_newline();
        end else begin
            emit(cs_pkg::KIND_TEXT, b, 1'b0);
        end
    endtask

    task automatic quoted_byte(input logic [7:0] b, input logic last);
        if (b == cs_pkg::CH_BSL) begin
            if (last) emit(cs_pkg::KIND_TEXT, b, 1'b0);
            else mode_q = cs_pkg::MODE_BSL;
        end else if (b == cs_pkg::CH_QUOTE) begin
            emit(cs_pkg::KIND_TEXT, b, 1'b0);
            mode_q = cs_pkg::MODE_NORMAL;
        end else if (b == cs_pkg::CH_NL) begin
            emit(cs_pkg::KIND_STR_NL, 8'h00, 1'b0);
            mode_q = cs_pkg::MODE_ERROR;
        end else begin
            emit(cs_pkg::KIND_TEXT, b, 1'b0);
        end
    endtask

    // expected beats for one accepted byte
    task automatic strip_step(input logic [7:0] b, input logic last, input bit record);
        rec_on = record;
        case (mode_q)
            cs_pkg::MODE_NORMAL: plain_byte(b, last);
            cs_pkg::MODE_SLASH: begin
                if (b == cs_pkg::CH_SLASH) begin
                    mode_q = cs_pkg::MODE_LINE;
                end else if (b == cs_pkg::CH_STAR) begin
                    mode_q = cs_pkg::MODE_BLOCK;
                end else begin
                    emit(cs_pkg::KIND_TEXT, cs_pkg::CH_SLASH, 1'b0);
                    mode_q = cs_pkg::MODE_NORMAL;
                    plain_byte(b, last);
                end
            end
            cs_pkg::MODE_LINE: begin
                if (b == cs_pkg::CH_NL) begin
                    pass_newline();
                    mode_q = cs_pkg::MODE_NORMAL;
                end
            end
            cs_pkg::MODE_BLOCK, cs_pkg::MODE_STAR: begin
                if (mode_q == cs_pkg::MODE_STAR && b == cs_pkg::CH_SLASH) begin
                    mode_q = cs_pkg::MODE_NORMAL;
                end else if (b == cs_pkg::CH_STAR) begin
                    mode_q = cs_pkg::MODE_STAR;
                end else begin
                    if (b == cs_pkg::CH_NL) pass_newline();
                    mode_q = cs_pkg::MODE_BLOCK;
                end
            end
            cs_pkg::MODE_STRING: quoted_byte(b, last);
            cs_pkg::MODE_BSL: begin
                emit(cs_pkg::KIND_TEXT, cs_pkg::CH_BSL, 1'b0);
                mode_q = cs_pkg::MODE_STRING;
                if (b == cs_pkg::CH_QUOTE) emit(cs_pkg::KIND_TEXT, cs_pkg::CH_QUOTE, 1'b0);
                else quoted_byte(b, last);
            end
            default: ;
        endcase
        // end of text closes any open comment and restarts the scan
        if (last) begin
            if (mode_q == cs_pkg::MODE_BLOCK || mode_q == cs_pkg::MODE_STAR)
                emit(cs_pkg::KIND_OPEN_BLOCK, 8'h00, 1'b0);
            emit(cs_pkg::KIND_END, 8'h00, 1'b1);
            mode_q = cs_pkg::MODE_NORMAL;
            line_q = cs_pkg::OUT_LINE_W'(1);
        end
    endtask

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------

    // offer one beat in bursts with random gaps, predict on acceptance
    task automatic send_byte(input logic [7:0] b, input logic last, input bit record);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        strip_step(b, last, record);
    endtask

    // stop offering until every predicted beat has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_beats.size() != 0);
        burst_left = 0;
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    // build one text out of comment, string and plain fragments
    task automatic build_text();
        int target;
        int run;
        text_q.delete();
        target = $urandom_range(3, 30);
        while (text_q.size() < target) begin
            run = $urandom_range(0, 5);
            case ($urandom_range(0, 9))
                0, 1: repeat (run + 1) add_text(printable());
                2: add_text(cs_pkg::CH_NL);
                3: begin
                    add_text(cs_pkg::CH_SLASH);
                    add_text(cs_pkg::CH_SLASH);
                    repeat (run) add_text(printable());
                    add_text(cs_pkg::CH_NL);
                end
                4: begin
                    add_text(cs_pkg::CH_SLASH);
                    add_text(cs_pkg::CH_STAR);
                    repeat (run) begin
                        case ($urandom_range(0, 3))
                            0: add_text(cs_pkg::CH_STAR);
                            1: add_text(cs_pkg::CH_NL);
                            default: add_text(printable());
                        endcase
                    end
                    // sometimes left open
                    if ($urandom_range(0, 4) != 0) begin
                        add_text(cs_pkg::CH_STAR);
                        add_text(cs_pkg::CH_SLASH);
                    end
                end
                5: begin
                    add_text(cs_pkg::CH_QUOTE);
                    repeat (run) begin
                        case ($urandom_range(0, 3))
                            0: begin
                                add_text(cs_pkg::CH_BSL);
                                add_text(cs_pkg::CH_QUOTE);
                            end
                            1: begin
                                add_text(cs_pkg::CH_BSL);
                                add_text(printable());
                            end
                            default: add_text(printable());
                        endcase
                    end
                    add_text(cs_pkg::CH_QUOTE);
                end
                6: begin
                    // string broken by a newline
                    add_text(cs_pkg::CH_QUOTE);
                    repeat (run) add_text(printable());
                    add_text(cs_pkg::CH_NL);
                end
                7: begin
                    add_text(cs_pkg::CH_SLASH);
                    add_text(printable());
                end
                8: repeat (run + 1) add_text(8'($urandom_range(0, 255)));
                default: begin
                    add_text(cs_pkg::CH_STAR);
                    add_text(cs_pkg::CH_STAR);
                    add_text(cs_pkg::CH_SLASH);
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // receiver
    // ---------------------------------------------------------------

    // stall pattern that changes style now and then, plus long holds on request
    initial begin
        rx_style_t style;
        int        style_left;
        int        hold_left;
        int        holds_seen;
        style      = RX_OPEN;
        style_left = 0;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge aclk);
            if (holds_seen != hold_asks) begin
                holds_seen = hold_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (style_left == 0) begin
                style      = rx_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(20, 200);
            end
            style_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (style)
                    RX_OPEN:     m_tready <= 1'b1;
                    RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_tready <= (cycle_cnt[1:0] != 2'd0);
                    default:     m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // result check
    // ---------------------------------------------------------------

    task automatic note_mismatch(input string msg);
        if (mismatches < 10) $display("%s", msg);
        mismatches++;
    endtask

    // compare each result beat with the oldest prediction
    always @(posedge aclk) begin : watch_results
        cs_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beats.size() == 0) begin
                note_mismatch($sformatf("unexpected beat: kind %0d byte %02h line %0d last %0b",
                                        m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast));
            end else begin
                want = pending_beats.pop_front();
                if (m_tuser !== want.kind || m_tdata[7:0] !== want.data ||
                    m_tdata[23:8] !== want.line || m_tlast !== want.last) begin
                    note_mismatch($sformatf(
                        {"mismatch: want kind %0d byte %02h line %0d last %0b, ",
                         "got kind %0d byte %02h line %0d last %0b"},
                        want.kind, want.data, want.line, want.last,
                        m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    function automatic cs_pkg::result_t res(input cs_pkg::kind_t k, input logic [7:0] d,
                                            input int ln, input logic fin);
        cs_pkg::result_t r;
        r.kind = k;
        r.data = d;
        r.line = cs_pkg::OUT_LINE_W'(ln);
        r.last = fin;
        return r;
    endfunction

    function automatic dir_row_t trow(input logic [7:0] b, input logic last, input int n,
                                      input cs_pkg::result_t r0, input cs_pkg::result_t r1,
                                      input cs_pkg::result_t r2);
        dir_row_t row;
        row.data  = b;
        row.last  = last;
        row.typed = 1'b1;
        row.n_res = 2'(n);
        row.res   = {r2, r1, r0};
        return row;
    endfunction

    function automatic dir_row_t prow(input logic [7:0] b, input logic last);
        dir_row_t row;
        row       = '0;
        row.data  = b;
        row.last  = last;
        return row;
    endfunction

    initial begin
        int random_sent;
        bit hold_done;
        bit first_text;

        // plain bytes at the extremes, newlines and a line comment
        dir_tab.insert(dir_tab.size(), trow(8'h78, 1'b0, 1,
                       res(cs_pkg::KIND_TEXT, 8'h78, 1, 1'b0), '0, '0));
        dir_tab.insert(dir_tab.size(), trow(8'h00, 1'b0, 1,
                       res(cs_pkg::KIND_TEXT, 8'h00, 1, 1'b0), '0, '0));
        dir_tab.insert(dir_tab.size(), trow(8'hff, 1'b0, 1,
                       res(cs_pkg::KIND_TEXT, 8'hff, 1, 1'b0), '0, '0));
        dir_tab.insert(dir_tab.size(), trow(cs_pkg::CH_NL, 1'b0, 1,
                       res(cs_pkg::KIND_TEXT, cs_pkg::CH_NL, 1, 1'b0), '0, '0));
        dir_tab.insert(dir_tab.size(), trow(cs_pkg::CH_SLASH, 1'b0, 0, '0, '0, '0));
        dir_tab.insert(dir_tab.size(), trow(cs_pkg::CH_SLASH, 1'b0, 0, '0, '0, '0));
        dir_tab.insert(dir_tab.size(), trow(8'hff, 1'b0, 0, '0, '0, '0));
        dir_tab.insert(dir_tab.size(), trow(cs_pkg::CH_NL, 1'b0, 1,
                       res(cs_pkg::KIND_TEXT, cs_pkg::CH_NL, 2, 1'b0), '0, '0));
        // block comment with a newline inside, closed by star slash
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_SLASH, 1'b0));
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_STAR, 1'b0));
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_NL, 1'b0));
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_STAR, 1'b0));
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_SLASH, 1'b0));
        // held slash released by a plain byte
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_SLASH, 1'b0));
        dir_tab.insert(dir_tab.size(), prow(8'h61, 1'b0));
        // string with an escaped quote, a kept backslash, then broken by newline
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_QUOTE, 1'b0));
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_BSL, 1'b0));
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_QUOTE, 1'b0));
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_BSL, 1'b0));
        dir_tab.insert(dir_tab.size(), prow(8'h6e, 1'b0));
        dir_tab.insert(dir_tab.size(), trow(cs_pkg::CH_NL, 1'b0, 1,
                       res(cs_pkg::KIND_STR_NL, 8'h00, 4, 1'b0), '0, '0));
        // error mode drops bytes until the final one
        dir_tab.insert(dir_tab.size(), trow(8'h7a, 1'b0, 0, '0, '0, '0));
        dir_tab.insert(dir_tab.size(), trow(8'h7a, 1'b1, 1,
                       res(cs_pkg::KIND_END, 8'h00, 4, 1'b1), '0, '0));
        // held slash on the final byte
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_SLASH, 1'b1));
        // held backslash on the final byte, string left open
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_QUOTE, 1'b0));
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_BSL, 1'b1));
        // block comment still open at the final byte
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_SLASH, 1'b0));
        dir_tab.insert(dir_tab.size(), prow(cs_pkg::CH_STAR, 1'b0));
        dir_tab.insert(dir_tab.size(), trow(8'h63, 1'b1, 2,
                       res(cs_pkg::KIND_OPEN_BLOCK, 8'h00, 1, 1'b0),
                       res(cs_pkg::KIND_END, 8'h00, 1, 1'b1), '0));

        // reset
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (dir_tab[i]) begin
            send_byte(dir_tab[i].data, dir_tab[i].last, !dir_tab[i].typed);
            if (dir_tab[i].typed) begin
                for (int j = 0; j < dir_tab[i].n_res; j++)
                    add_beat(dir_tab[i].res[j]);
            end
        end
        drain();

        // random texts, with one long receiver hold and pauses between texts
        random_sent = 0;
        hold_done   = 1'b0;
        first_text  = 1'b1;
        while (random_sent < RANDOM_ITEMS) begin
            build_text();
            foreach (text_q[i]) begin
                if (!hold_done && random_sent >= RANDOM_ITEMS / 3) begin
                    hold_asks++;
                    hold_done = 1'b1;
                end
                send_byte(text_q[i], i == text_q.size() - 1, 1'b1);
                random_sent++;
            end
            if (first_text || $urandom_range(0, 5) == 0) drain();
            first_text = 1'b0;
        end

        // wait for the tail and let the pipeline settle
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
